// ===== src/cscc_pkg.sv =====
// Package for the cycling speed/cadence calculator.
// Field widths, reset value and the divider control bundle.
// No dependencies.
package cscc_pkg;

    localparam int CIRC_W    = 12;
    localparam int REV_W     = 32;
    localparam int CRANK_W   = 16;
    localparam int TIME_W    = 16;
    localparam int DIST_W    = REV_W + CIRC_W;
    localparam int RES_W     = 32;
    localparam int TICK_SH   = 10;
    localparam int DIV_NUM_W = DIST_W + TICK_SH;

    localparam logic [CIRC_W-1:0] CIRC_RESET = 12'd2200;

    typedef struct packed {
        logic load;
        logic step;
    } t_div_ctrl;

endpackage

// ===== src/cscc_div.sv =====
// Bit-serial restoring divider: one quotient bit per step cycle; 32-bit saturating.
// Depends on cscc_pkg.
module cscc_div #(
    parameter int NUM_W = cscc_pkg::DIV_NUM_W
) (
    input  logic                              i_clk,
    input  cscc_pkg::t_div_ctrl               i_ctrl,
    input  logic [NUM_W-1:0]                  i_num,
    input  logic [cscc_pkg::TIME_W-1:0]       i_den,
    output logic [cscc_pkg::RES_W-1:0]        o_quot
);
    import cscc_pkg::*;

    logic [NUM_W-1:0]  r_num;
    logic [TIME_W-1:0] r_den;
    logic [TIME_W-1:0] r_rem;
    logic [RES_W-1:0]  r_q;
    logic              r_ovf;

    logic [TIME_W:0]   w_trial;
    logic              w_ge;
    logic [TIME_W:0]   w_diff;

    assign w_trial = {r_rem, r_num[NUM_W-1]};
    assign w_ge    = w_trial >= {1'b0, r_den};
    assign w_diff  = w_trial - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (i_ctrl.load) begin
            r_num <= i_num;
            r_den <= i_den;
            r_rem <= '0;
            r_q   <= '0;
            r_ovf <= 1'b0;
        end else if (i_ctrl.step) begin
            r_num <= {r_num[NUM_W-2:0], 1'b0};
            r_rem <= w_ge ? w_diff[TIME_W-1:0] : w_trial[TIME_W-1:0];
            r_q   <= {r_q[RES_W-2:0], w_ge};
            r_ovf <= r_ovf | r_q[RES_W-1];
        end
    end

    assign o_quot = r_ovf ? '1 : r_q;

endmodule

// ===== src/cycling_speed_cadence_calc.sv =====
// Cycling speed/cadence calculator top level: handshake, state, serial multiply.
// Depends on cscc_pkg and cscc_div.
//
// One measurement is taken at a time. An accepted item goes through shift-add
// multiplication by the circumference (S_MUL), one load step (S_LOAD) and
// bit-serial division (S_DIV, three divider lanes run side by side, one step
// per numerator bit of the speed term), after which a result is offered; the
// next item is taken once that result has been delivered. Circumference
// writes take effect for the next item.
module cycling_speed_cadence_calc (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [cscc_pkg::CIRC_W-1:0]       i_cfg_data,
    input  logic                              i_valid,
    output logic                              o_stall,
    input  logic                              i_has_wheel,
    input  logic [cscc_pkg::REV_W-1:0]        i_wheel_revs,
    input  logic [cscc_pkg::TIME_W-1:0]       i_wheel_time,
    input  logic                              i_has_crank,
    input  logic [cscc_pkg::CRANK_W-1:0]      i_crank_revs,
    input  logic [cscc_pkg::TIME_W-1:0]       i_crank_time,
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic                              o_wheel_valid,
    output logic [cscc_pkg::RES_W-1:0]        o_speed_mm_per_s,
    output logic [cscc_pkg::RES_W-1:0]        o_wheel_rpm,
    output logic [cscc_pkg::DIST_W-1:0]       o_sensor_distance_mm,
    output logic [cscc_pkg::DIST_W-1:0]       o_trip_distance_mm,
    output logic                              o_crank_valid,
    output logic [cscc_pkg::RES_W-1:0]        o_crank_rpm
);
    import cscc_pkg::*;

    typedef enum logic [1:0] {S_IDLE, S_MUL, S_LOAD, S_DIV} t_state;

    localparam logic [5:0] MUL_LAST = 6'(CIRC_W - 1);
    localparam logic [5:0] DIV_LAST = 6'(DIV_NUM_W - 1);

    t_state              r_state;
    logic [5:0]          r_cnt;
    logic                r_out;
    logic [CIRC_W-1:0]   r_circ;
    logic [CIRC_W-1:0]   r_csh;

    logic                r_wheel_seen;
    logic [REV_W-1:0]    r_first_wheel;
    logic [REV_W-1:0]    r_prev_wheel;
    logic [TIME_W-1:0]   r_prev_wtime;
    logic                r_crank_seen;
    logic [CRANK_W-1:0]  r_prev_crank;
    logic [TIME_W-1:0]   r_prev_ctime;

    logic                r_wv;
    logic                r_cv;
    logic [REV_W-1:0]    r_revs;
    logic [REV_W-1:0]    r_trip;
    logic [REV_W-1:0]    r_dr;
    logic [CRANK_W-1:0]  r_dc;
    logic [TIME_W-1:0]   r_dtw;
    logic [TIME_W-1:0]   r_dtc;
    logic [DIST_W-1:0]   r_p_revs;
    logic [DIST_W-1:0]   r_p_trip;
    logic [DIST_W-1:0]   r_p_dr;

    logic                w_acc;
    logic                w_wcalc;
    logic                w_ccalc;
    logic [CRANK_W-1:0]  w_dc;
    logic [REV_W+15:0]   w_rpm_num;
    logic [RES_W-1:0]    w_crank_num;
    t_div_ctrl           w_dctl;
    logic [RES_W-1:0]    w_q_speed;
    logic [RES_W-1:0]    w_q_rpm;
    logic [RES_W-1:0]    w_q_crank;

    assign w_acc   = i_valid && !o_stall;
    assign w_wcalc = i_has_wheel && r_wheel_seen && (i_wheel_time != r_prev_wtime);
    assign w_ccalc = i_has_crank && r_crank_seen && (i_crank_time != r_prev_ctime);
    assign w_dc    = i_crank_revs - r_prev_crank;

    // x*61440 = (x << 16) - (x << 12)
    assign w_rpm_num   = {r_dr, 16'b0} - {4'b0, r_dr, 12'b0};
    assign w_crank_num = {r_dc, 16'b0} - {4'b0, r_dc, 12'b0};

    assign w_dctl.load = (r_state == S_LOAD);
    assign w_dctl.step = (r_state == S_DIV);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_cnt        <= '0;
            r_out        <= 1'b0;
            r_circ       <= CIRC_RESET;
            r_wheel_seen <= 1'b0;
            r_first_wheel <= '0;
            r_prev_wheel <= '0;
            r_prev_wtime <= '0;
            r_crank_seen <= 1'b0;
            r_prev_crank <= '0;
            r_prev_ctime <= '0;
        end else begin
            if (i_cfg_we) begin
                r_circ <= i_cfg_data;
            end
            if (r_out && !i_stall) begin
                r_out <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_acc) begin
                        r_state <= S_MUL;
                        r_cnt   <= MUL_LAST;
                        r_csh   <= r_circ;
                        r_p_revs <= '0;
                        r_p_trip <= '0;
                        r_p_dr   <= '0;
                        r_wv    <= w_wcalc;
                        r_cv    <= w_ccalc && (w_dc != '0);
                        r_revs  <= i_wheel_revs;
                        r_trip  <= i_wheel_revs - r_first_wheel;
                        r_dr    <= i_wheel_revs - r_prev_wheel;
                        r_dtw   <= i_wheel_time - r_prev_wtime;
                        r_dc    <= w_dc;
                        r_dtc   <= i_crank_time - r_prev_ctime;
                        if (i_has_wheel && !r_wheel_seen) begin
                            r_first_wheel <= i_wheel_revs;
                            r_prev_wheel  <= i_wheel_revs;
                            r_prev_wtime  <= i_wheel_time;
                            r_wheel_seen  <= 1'b1;
                        end else if (w_wcalc) begin
                            r_prev_wheel  <= i_wheel_revs;
                            r_prev_wtime  <= i_wheel_time;
                        end
                        if (i_has_crank && (!r_crank_seen || w_ccalc)) begin
                            r_prev_crank <= i_crank_revs;
                            r_prev_ctime <= i_crank_time;
                            r_crank_seen <= 1'b1;
                        end
                    end
                end
                S_MUL: begin
                    r_csh    <= {r_csh[CIRC_W-2:0], 1'b0};
                    r_p_revs <= {r_p_revs[DIST_W-2:0], 1'b0}
                              + (r_csh[CIRC_W-1] ? {{CIRC_W{1'b0}}, r_revs} : '0);
                    r_p_trip <= {r_p_trip[DIST_W-2:0], 1'b0}
                              + (r_csh[CIRC_W-1] ? {{CIRC_W{1'b0}}, r_trip} : '0);
                    r_p_dr   <= {r_p_dr[DIST_W-2:0], 1'b0}
                              + (r_csh[CIRC_W-1] ? {{CIRC_W{1'b0}}, r_dr} : '0);
                    if (r_cnt == '0) begin
                        r_state <= S_LOAD;
                    end else begin
                        r_cnt <= r_cnt - 6'd1;
                    end
                end
                S_LOAD: begin
                    r_state <= S_DIV;
                    r_cnt   <= DIV_LAST;
                end
                S_DIV: begin
                    if (r_cnt == '0) begin
                        r_state <= S_IDLE;
                        r_out   <= 1'b1;
                    end else begin
                        r_cnt <= r_cnt - 6'd1;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    cscc_div #(.NUM_W(DIV_NUM_W)) u_div_speed (
        .i_clk  (i_clk),
        .i_ctrl (w_dctl),
        .i_num  ({r_p_dr, {TICK_SH{1'b0}}}),
        .i_den  (r_dtw),
        .o_quot (w_q_speed)
    );

    cscc_div #(.NUM_W(DIV_NUM_W)) u_div_rpm (
        .i_clk  (i_clk),
        .i_ctrl (w_dctl),
        .i_num  ({{(DIV_NUM_W-REV_W-16){1'b0}}, w_rpm_num}),
        .i_den  (r_dtw),
        .o_quot (w_q_rpm)
    );

    cscc_div #(.NUM_W(DIV_NUM_W)) u_div_crank (
        .i_clk  (i_clk),
        .i_ctrl (w_dctl),
        .i_num  ({{(DIV_NUM_W-RES_W){1'b0}}, w_crank_num}),
        .i_den  (r_dtc),
        .o_quot (w_q_crank)
    );

    assign o_stall              = (r_state != S_IDLE) || r_out;
    assign o_valid              = r_out;
    assign o_wheel_valid        = r_wv;
    assign o_speed_mm_per_s     = r_wv ? w_q_speed : '0;
    assign o_wheel_rpm          = r_wv ? w_q_rpm : '0;
    assign o_sensor_distance_mm = r_wv ? r_p_revs : '0;
    assign o_trip_distance_mm   = r_wv ? r_p_trip : '0;
    assign o_crank_valid        = r_cv;
    assign o_crank_rpm          = r_cv ? w_q_crank : '0;

endmodule

// ===== src/cscc_checker.sv =====
// Port-level checks for the cycling speed/cadence calculator, bound to the top level.
// Depends on cscc_pkg.
module cscc_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              i_valid,
    input logic                              o_stall,
    input logic                              o_valid,
    input logic                              i_stall,
    input logic                              o_wheel_valid,
    input logic [cscc_pkg::RES_W-1:0]        o_speed_mm_per_s,
    input logic [cscc_pkg::RES_W-1:0]        o_wheel_rpm,
    input logic [cscc_pkg::DIST_W-1:0]       o_sensor_distance_mm,
    input logic [cscc_pkg::DIST_W-1:0]       o_trip_distance_mm,
    input logic                              o_crank_valid,
    input logic [cscc_pkg::RES_W-1:0]        o_crank_rpm
);
    import cscc_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid)
        else $error("result item dropped while stalled");

    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_stall |-> !o_valid)
        else $error("input taken while result pending");

    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> o_stall)
        else $error("not busy after item accepted");

    a_wheel_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_wheel_valid |-> o_speed_mm_per_s == '0 && o_wheel_rpm == '0
            && o_sensor_distance_mm == '0 && o_trip_distance_mm == '0)
        else $error("wheel fields nonzero without wheel_valid");

    a_crank_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_crank_valid |-> o_crank_rpm == '0)
        else $error("crank rpm nonzero without crank_valid");

endmodule

bind cycling_speed_cadence_calc cscc_checker u_cscc_checker (.*);

// ===== tb/cycling_speed_cadence_calc_test.sv =====
// Self-checking testbench for cycling_speed_cadence_calc: speed, rpm, distance and cadence.
// Drives measurement items from a queue, predicts each result, compares at the output.
// Depends on cscc_pkg and the cycling_speed_cadence_calc RTL.
`timescale 1ns / 1ps

module cycling_speed_cadence_calc_test;
    import cscc_pkg::*;

    localparam int LATENCY   = 80;
    localparam int MAX_CYCLE = 1500000;

    typedef struct packed {
        logic                has_wheel;
        logic [REV_W-1:0]    wheel_revs;
        logic [TIME_W-1:0]   wheel_time;
        logic                has_crank;
        logic [CRANK_W-1:0]  crank_revs;
        logic [TIME_W-1:0]   crank_time;
    } t_meas;

    typedef struct packed {
        logic                wheel_valid;
        logic [RES_W-1:0]    speed;
        logic [RES_W-1:0]    wheel_rpm;
        logic [DIST_W-1:0]   sensor_dist;
        logic [DIST_W-1:0]   trip_dist;
        logic                crank_valid;
        logic [RES_W-1:0]    crank_rpm;
    } t_ride;

    logic i_clk = 0;
    logic i_rst_n = 0;
    logic i_cfg_we = 0;
    logic [CIRC_W-1:0] i_cfg_data = '0;
    logic i_valid = 0;
    logic o_stall;
    logic i_has_wheel = 0;
    logic [REV_W-1:0] i_wheel_revs = '0;
    logic [TIME_W-1:0] i_wheel_time = '0;
    logic i_has_crank = 0;
    logic [CRANK_W-1:0] i_crank_revs = '0;
    logic [TIME_W-1:0] i_crank_time = '0;
    logic o_valid;
    logic i_stall = 1;
    logic o_wheel_valid, o_crank_valid;
    logic [RES_W-1:0] o_speed_mm_per_s, o_wheel_rpm, o_crank_rpm;
    logic [DIST_W-1:0] o_sensor_distance_mm, o_trip_distance_mm;

    cycling_speed_cadence_calc u_dut (.*);

    always #10 i_clk = ~i_clk;

    // predictor state
    logic [CIRC_W-1:0]  circ_mm;
    logic               wheel_seen, crank_seen;
    logic [REV_W-1:0]   first_wheel, last_wheel;
    logic [TIME_W-1:0]  last_wheel_t, last_crank_t;
    logic [CRANK_W-1:0] last_crank;

    t_meas pending_meas[$];
    t_ride expected_rides[$];
    int    errors = 0;
    int    cycle = 0;
    int    long_hold = 0;
    int    tx_gap = 0, rx_gap = 0;
    bit    feeding = 0;
    bit    rx_run = 0;
    bit    in_taken = 0;

    function automatic logic [31:0] sat32(logic [63:0] v);
        return (v > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : v[31:0];
    endfunction

    function automatic t_ride predict_ride(t_meas m);
        t_ride r;
        logic [63:0] dt, dr, trip, dc;
        r = '0;
        if (m.has_wheel) begin
            if (!wheel_seen) begin
                first_wheel = m.wheel_revs;
                last_wheel = m.wheel_revs;
                last_wheel_t = m.wheel_time;
                wheel_seen = 1;
            end else if (m.wheel_time != last_wheel_t) begin
                dt = 64'(16'(m.wheel_time - last_wheel_t));
                dr = 64'(32'(m.wheel_revs - last_wheel));
                trip = 64'(32'(m.wheel_revs - first_wheel));
                r.wheel_valid = 1;
                r.speed = sat32(dr * 64'(circ_mm) * 1024 / dt);
                r.wheel_rpm = sat32(dr * 60 * 1024 / dt);
                r.sensor_dist = DIST_W'(64'(m.wheel_revs) * 64'(circ_mm));
                r.trip_dist = DIST_W'(trip * 64'(circ_mm));
                last_wheel = m.wheel_revs;
                last_wheel_t = m.wheel_time;
            end
        end
        if (m.has_crank) begin
            if (!crank_seen) begin
                last_crank = m.crank_revs;
                last_crank_t = m.crank_time;
                crank_seen = 1;
            end else if (m.crank_time != last_crank_t) begin
                dt = 64'(16'(m.crank_time - last_crank_t));
                dc = 64'(16'(m.crank_revs - last_crank));
                if (dc != 0) begin
                    r.crank_valid = 1;
                    r.crank_rpm = sat32(dc * 60 * 1024 / dt);
                end
                last_crank = m.crank_revs;
                last_crank_t = m.crank_time;
            end
        end
        return r;
    endfunction

    function automatic int pick_gap();
        int p;
        p = $urandom_range(0, 99);
        if (p < 50) return 0;
        if (p < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 120);
    endfunction

    // driver
    always @(negedge i_clk) begin
        if (!i_valid || in_taken) begin
            in_taken = 0;
            if (feeding && pending_meas.size() > 0 && tx_gap == 0) begin
                i_valid <= 1;
                {i_has_wheel, i_wheel_revs, i_wheel_time,
                 i_has_crank, i_crank_revs, i_crank_time} <= pending_meas[0];
            end else begin
                i_valid <= 0;
                if (tx_gap > 0) tx_gap = tx_gap - 1;
            end
        end
        // receiver stall
        if (!rx_run) i_stall <= 1;
        else if (long_hold > 0) begin
            long_hold = long_hold - 1;
            i_stall <= 1;
        end else if (rx_gap > 0) begin
            rx_gap = rx_gap - 1;
            i_stall <= 1;
        end else begin
            i_stall <= 0;
            rx_gap = pick_gap();
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_ride got, exp_r;
        cycle <= cycle + 1;
        if (cycle > MAX_CYCLE) begin
            $display("cycling_speed_cadence_calc verification failed");
            $finish;
        end
        if (i_rst_n && i_valid && !o_stall) begin
            expected_rides.push_back(predict_ride(pending_meas.pop_front()));
            tx_gap = pick_gap();
            in_taken = 1;
        end
        if (i_rst_n && o_valid && !i_stall) begin
            got = {o_wheel_valid, o_speed_mm_per_s, o_wheel_rpm, o_sensor_distance_mm,
                   o_trip_distance_mm, o_crank_valid, o_crank_rpm};
            if (expected_rides.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected result %h", got);
            end else begin
                exp_r = expected_rides.pop_front();
                if (got !== exp_r) begin
                    errors++;
                    if (errors <= 10)
                        $display("mismatch exp wv=%0d spd=%0d rpm=%0d sd=%0d td=%0d cv=%0d cr=%0d",
                                 exp_r.wheel_valid, exp_r.speed, exp_r.wheel_rpm,
                                 exp_r.sensor_dist, exp_r.trip_dist, exp_r.crank_valid,
                                 exp_r.crank_rpm);
                    if (errors <= 10)
                        $display("         got wv=%0d spd=%0d rpm=%0d sd=%0d td=%0d cv=%0d cr=%0d",
                                 got.wheel_valid, got.speed, got.wheel_rpm, got.sensor_dist,
                                 got.trip_dist, got.crank_valid, got.crank_rpm);
                end
            end
        end
    end

    function automatic t_meas rand_meas(ref logic [31:0] revs, ref logic [15:0] wt,
                                        ref logic [15:0] cr, ref logic [15:0] ct);
        t_meas m;
        int p;
        p = $urandom_range(0, 99);
        if (p < 8) begin
            m = {1'($urandom_range(0, 1)), 32'($urandom), 16'($urandom),
                 1'($urandom_range(0, 1)), 16'($urandom), 16'($urandom)};
            return m;
        end
        revs = revs + (p < 15 ? $urandom : $urandom_range(0, 8));
        if ($urandom_range(0, 9) != 0)
            wt = wt + (p < 20 ? 16'($urandom) : 16'($urandom_range(200, 3000)));
        cr = cr + (p < 25 ? 16'($urandom) : 16'($urandom_range(0, 3)));
        if ($urandom_range(0, 9) != 0)
            ct = ct + (p < 30 ? 16'($urandom) : 16'($urandom_range(200, 3000)));
        m.has_wheel = ($urandom_range(0, 9) != 0);
        m.wheel_revs = revs;
        m.wheel_time = wt;
        m.has_crank = ($urandom_range(0, 9) != 0);
        m.crank_revs = cr;
        m.crank_time = ct;
        return m;
    endfunction

    task automatic drain();
        while (pending_meas.size() > 0 || expected_rides.size() > 0 || i_valid)
            @(posedge i_clk);
        repeat (LATENCY) @(posedge i_clk);
    endtask

    task automatic set_circ(logic [CIRC_W-1:0] c);
        @(negedge i_clk);
        i_cfg_we <= 1;
        i_cfg_data <= c;
        @(negedge i_clk);
        i_cfg_we <= 0;
        circ_mm = c;
    endtask

    initial begin
        logic [31:0] revs;
        logic [15:0] wt, cr, ct;
        logic [CIRC_W-1:0] circ_list[5];
        circ_list = '{12'd1, 12'd4095, 12'd2100, 12'd1, 12'd700};
        circ_mm = CIRC_RESET;
        wheel_seen = 0; crank_seen = 0;
        first_wheel = 0; last_wheel = 0; last_wheel_t = 0;
        last_crank = 0; last_crank_t = 0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1;

        // directed: priming, repeats, wrap, saturation, zero crank delta, small cadence
        pending_meas.push_back({1'b0, 32'hFFFF_FFFF, 16'hFFFF, 1'b0, 16'hFFFF, 16'hFFFF});
        pending_meas.push_back({1'b1, 32'd100, 16'd65000, 1'b1, 16'd10, 16'd65000});
        pending_meas.push_back({1'b1, 32'd105, 16'd65000, 1'b1, 16'd12, 16'd65000});
        pending_meas.push_back({1'b1, 32'd105, 16'd1000, 1'b1, 16'd12, 16'd1000});
        pending_meas.push_back({1'b1, 32'hFFFF_FFFF, 16'd1001, 1'b1, 16'd11, 16'd1001});
        pending_meas.push_back({1'b1, 32'd3, 16'd1002, 1'b1, 16'd12, 16'd1002});
        pending_meas.push_back({1'b1, 32'd4, 16'd1001, 1'b1, 16'd13, 16'd1001});
        pending_meas.push_back({1'b0, 32'd0, 16'd0, 1'b1, 16'd0, 16'd0});
        pending_meas.push_back({1'b1, 32'd0, 16'd0, 1'b0, 16'd0, 16'd0});
        pending_meas.push_back({1'b1, 32'h8000_0000, 16'hFFFF, 1'b1, 16'h8000, 16'hFFFF});
        feeding = 1;
        rx_run = 1;
        long_hold = 400;
        drain();

        for (int ph = 0; ph < 5; ph++) begin
            set_circ(circ_list[ph]);
            revs = $urandom; wt = 16'($urandom); cr = 16'($urandom); ct = 16'($urandom);
            for (int n = 0; n < 80; n++)
                pending_meas.push_back(rand_meas(revs, wt, cr, ct));
            if (ph == 2) long_hold = 600;
            drain();
        end

        if (errors == 0)
            $display("cycling_speed_cadence_calc verification clean");
        else
            $display("cycling_speed_cadence_calc verification failed");
        $finish;
    end
endmodule

// ===== filelist.f =====
src/cscc_pkg.sv
src/cscc_div.sv
src/cycling_speed_cadence_calc.sv
src/cscc_checker.sv
tb/cycling_speed_cadence_calc_test.sv
